/* rtl/bwtm_pkg.sv */
`timescale 1ns / 1ps

package bwtm_pkg;

  // operation field of an input request
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // configuration register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_CODES  = 3'd2,
    REG_THRESH = 3'd3,
    REG_FG     = 3'd4,
    REG_BG     = 3'd5
  } reg_e;

  // action codes
  localparam logic [1:0] ACT_ZERO = 2'd0;
  localparam logic [1:0] ACT_ONE  = 2'd1;
  localparam logic [1:0] ACT_KEEP = 2'd2;

  // template cell codes
  localparam logic [1:0] CELL_ZERO  = 2'd0;
  localparam logic [1:0] CELL_ONE   = 2'd1;
  localparam logic [1:0] CELL_NEVER = 2'd2;
  localparam logic [1:0] CELL_ANY   = 2'd3;

  localparam int unsigned CountW = 21;
  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  typedef struct packed {
    op_e  operation;
    logic pixel_in;
  } in_req_t;

  typedef struct packed {
    logic              pixel_out;
    logic              changed;
    logic              last;
    logic [CountW-1:0] change_count;
  } out_req_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [17:0] template_codes;
    logic [3:0]  match_required;
    logic [1:0]  fg_action;
    logic [1:0]  bg_action;
  } cfg_t;

  // border and framing info that travels with one window step
  typedef struct packed {
    logic emit;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
    logic restart;
  } win_ctl_t;

endpackage

/* rtl/bwtm_cfg_regs.sv */
`timescale 1ns / 1ps

module bwtm_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bwtm_pkg::cfg_t      cfg_o
);

  bwtm_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (bwtm_pkg::reg_e'(paddr[4:2]))
        bwtm_pkg::REG_WIDTH:  cfg_d.image_width    = pwdata[10:0];
        bwtm_pkg::REG_HEIGHT: cfg_d.image_height   = pwdata[10:0];
        bwtm_pkg::REG_CODES:  cfg_d.template_codes = pwdata[17:0];
        bwtm_pkg::REG_THRESH: cfg_d.match_required = pwdata[3:0];
        bwtm_pkg::REG_FG:     cfg_d.fg_action      = pwdata[1:0];
        bwtm_pkg::REG_BG:     cfg_d.bg_action      = pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (bwtm_pkg::reg_e'(paddr[4:2]))
      bwtm_pkg::REG_WIDTH:  prdata = {21'd0, cfg_q.image_width};
      bwtm_pkg::REG_HEIGHT: prdata = {21'd0, cfg_q.image_height};
      bwtm_pkg::REG_CODES:  prdata = {14'd0, cfg_q.template_codes};
      bwtm_pkg::REG_THRESH: prdata = {28'd0, cfg_q.match_required};
      bwtm_pkg::REG_FG:     prdata = {30'd0, cfg_q.fg_action};
      bwtm_pkg::REG_BG:     prdata = {30'd0, cfg_q.bg_action};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= 11'd1024;
      cfg_q.image_height   <= 11'd1024;
      cfg_q.template_codes <= 18'h3FFFF;
      cfg_q.match_required <= 4'd9;
      cfg_q.fg_action      <= bwtm_pkg::ACT_KEEP;
      cfg_q.bg_action      <= bwtm_pkg::ACT_KEEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/bwtm_line_mem.sv */
`timescale 1ns / 1ps

module bwtm_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [1:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [1:0]    wr_data_i
);

  // bit 1: row above, bit 0: row two above
  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // write-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/bwtm_scan_ctrl.sv */
`timescale 1ns / 1ps

module bwtm_scan_ctrl #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  bwtm_pkg::in_req_t             in_req_i,
  output logic                          in_stall_o,
  input  logic                          s1_adv_i,
  input  bwtm_pkg::cfg_t                cfg_i,
  output logic                          rd_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr_o,
  output logic                          s1_valid_o,
  output logic                          s1_px_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  s1_addr_o,
  output bwtm_pkg::win_ctl_t            s1_ctl_o
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT + 4);
  localparam int unsigned WCMP = (WW > 11) ? WW : 11;
  localparam int unsigned HCMP = (HW > 11) ? HW : 11;

  logic [CW-1:0] col_q, col_d, col_a;
  logic [RW-1:0] row_q, row_d, row_a, h_r, h1_r;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic          accept;
  logic          s1_valid_q, s1_px_q;
  logic [CW-1:0] s1_addr_q;
  bwtm_pkg::win_ctl_t ctl, s1_ctl_q;

  // clamp sizes to 1..max
  always_comb begin
    if (cfg_i.image_width == 11'd0) begin
      w = WW'(1);
    end else if (WCMP'(cfg_i.image_width) > WCMP'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg_i.image_width);
    end
    if (cfg_i.image_height == 11'd0) begin
      h = HW'(1);
    end else if (HCMP'(cfg_i.image_height) > HCMP'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(cfg_i.image_height);
    end
  end

  assign h_r  = RW'(h);
  assign h1_r = RW'(h) + RW'(1);

  assign in_stall_o = s1_valid_q & ~s1_adv_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    col_a       = col_q;
    row_a       = row_q;
    ctl         = '0;
    // wrap a column left past a narrowed width
    if (WW'(col_q) >= w) begin
      col_a = '0;
      row_a = row_q + RW'(1);
    end
    if (row_a > h1_r) begin
      col_a       = '0;
      row_a       = '0;
      ctl.restart = 1'b1;
    end
    if (col_a != '0) begin
      // centre one row and one column behind the input
      ctl.emit   = (row_a >= RW'(1)) && (row_a <= h_r);
      ctl.top    = (row_a == RW'(1));
      ctl.bottom = (row_a >= h_r);
      ctl.left   = (col_a == CW'(1));
      ctl.right  = 1'b0;
      ctl.last   = 1'b0;
    end else begin
      // centre at the end of the row two rows up
      ctl.emit   = (row_a >= RW'(2)) && (row_a <= h1_r);
      ctl.top    = (row_a == RW'(2));
      ctl.bottom = (row_a >= h1_r);
      ctl.left   = (w == WW'(1));
      ctl.right  = 1'b1;
      ctl.last   = (row_a == h1_r);
    end
    if (ctl.last) begin
      col_d = '0;
      row_d = '0;
    end else if ((WW'(col_a) + WW'(1)) >= w) begin
      col_d = '0;
      row_d = row_a + RW'(1);
    end else begin
      col_d = col_a + CW'(1);
      row_d = row_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= (in_req_i.operation == bwtm_pkg::OP_FLUSH) ? 1'b0 : in_req_i.pixel_in;
      s1_addr_q <= col_a;
      s1_ctl_q  <= ctl;
    end
  end

  assign rd_en_o    = accept;
  assign rd_addr_o  = col_a;
  assign s1_valid_o = s1_valid_q;
  assign s1_px_o    = s1_px_q;
  assign s1_addr_o  = s1_addr_q;
  assign s1_ctl_o   = s1_ctl_q;

endmodule

/* rtl/bwtm_match_core.sv */
`timescale 1ns / 1ps

module bwtm_match_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s1_valid_i,
  input  logic                s1_px_i,
  input  bwtm_pkg::win_ctl_t  s1_ctl_i,
  input  logic [1:0]          rd_data_i,
  input  bwtm_pkg::cfg_t      cfg_i,
  output logic                s1_adv_o,
  output logic                wr_en_o,
  output logic [1:0]          wr_data_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bwtm_pkg::out_req_t  out_req_o
);

  logic [8:0]  win_q, win_d;
  logic [2:0]  col_bits;
  logic [3:0]  count;
  logic        bit_v, hit, centre, res, chg, fire;
  logic [1:0]  code, act;
  logic [bwtm_pkg::CountW-1:0] fc_q, fc_d, base, cnt;
  logic        out_valid_q;
  bwtm_pkg::out_req_t out_req_q;

  assign s1_adv_o = ~out_valid_q | ~out_stall_i;
  assign fire     = s1_valid_i & s1_adv_o;

  // new column: input pixel, row above, row two above
  assign col_bits = {s1_px_i, rd_data_i[1], rd_data_i[0]};
  assign win_d    = {col_bits, win_q[8:3]};

  assign wr_en_o   = fire;
  assign wr_data_o = {s1_px_i, rd_data_i[1]};

  always_comb begin
    count = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        bit_v = win_d[3*j + i];
        if ((i == 0 && s1_ctl_i.top) || (i == 2 && s1_ctl_i.bottom) ||
            (j == 0 && s1_ctl_i.left) || (j == 2 && s1_ctl_i.right)) begin
          bit_v = 1'b0;
        end
        code = cfg_i.template_codes[2*(3*i + j) +: 2];
        hit  = (code == bwtm_pkg::CELL_ANY) ||
               ((code == bwtm_pkg::CELL_ZERO) && !bit_v) ||
               ((code == bwtm_pkg::CELL_ONE) && bit_v);
        count = count + 4'(hit);
      end
    end
  end

  always_comb begin
    centre = win_d[4];
    act    = (count >= cfg_i.match_required) ? cfg_i.fg_action : cfg_i.bg_action;
    case (act)
      bwtm_pkg::ACT_ZERO: res = 1'b0;
      bwtm_pkg::ACT_ONE:  res = 1'b1;
      default:            res = centre;
    endcase
    chg  = res ^ centre;
    base = s1_ctl_i.restart ? '0 : fc_q;
    cnt  = (chg && (base != bwtm_pkg::COUNT_MAX)) ? base + 1'b1 : base;
    fc_d = fc_q;
    if (fire) begin
      if (s1_ctl_i.emit) begin
        fc_d = s1_ctl_i.last ? '0 : cnt;
      end else begin
        fc_d = base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      fc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        win_q <= win_d;
      end
      fc_q <= fc_d;
      if (s1_adv_o) begin
        out_valid_q <= fire & s1_ctl_i.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s1_ctl_i.emit) begin
      out_req_q.pixel_out    <= res;
      out_req_q.changed      <= chg;
      out_req_q.last         <= s1_ctl_i.last;
      out_req_q.change_count <= cnt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

/* rtl/binary_window_template_match_unit.sv */
`timescale 1ns / 1ps
// pipeline: stage 1 registers, then the output register
// throughput: one request per cycle unless the output stalls, set by one line
// store read, one write back per cycle and the one-stage window evaluation
// reset: counters, window and change count clear, registers take defaults;
// the line store is not cleared, rows and columns outside the frame are masked

module binary_window_template_match_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel / flush requests
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bwtm_pkg::in_req_t   in_req_i,
  // results
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bwtm_pkg::out_req_t  out_req_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  bwtm_pkg::cfg_t     cfg;
  bwtm_pkg::win_ctl_t s1_ctl;
  logic               rd_en, wr_en, s1_adv, s1_valid, s1_px;
  logic [CW-1:0]      rd_addr, s1_addr;
  logic [1:0]         rd_data, wr_data;

  // register file; the user writes it only while the stream is idle, unchecked
  bwtm_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage 0: raster position, border flags, line store read
  bwtm_scan_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .s1_adv_i   (s1_adv),
    .cfg_i      (cfg),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .s1_valid_o (s1_valid),
    .s1_px_o    (s1_px),
    .s1_addr_o  (s1_addr),
    .s1_ctl_o   (s1_ctl)
  );

  // both line rows in one store; a write to the address being read is
  // forwarded so a one-pixel-wide frame still sees the previous row
  bwtm_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_lines (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr),
    .wr_data_i (wr_data)
  );

  // stage 1: window shift, template count, action, write back, output register
  bwtm_match_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_px_i     (s1_px),
    .s1_ctl_i    (s1_ctl),
    .rd_data_i   (rd_data),
    .cfg_i       (cfg),
    .s1_adv_o    (s1_adv),
    .wr_en_o     (wr_en),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

/* bench/binary_window_template_match_unit_test.sv */
`timescale 1ns / 1ps

module binary_window_template_match_unit_test;

  localparam int unsigned FrameMaxW    = 1024;
  localparam int unsigned FrameMaxH    = 1024;
  localparam int unsigned CycleLimit   = 500000;
  // output hold-off that lets the pipeline back up into the request side
  localparam int unsigned HoldCycles   = 300;
  // results pass the stage 1 and output registers, leave some margin before touching registers
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned RandomItems  = 200;

  // shadow of the match unit: line stores, window, frame counters and the
  // pixels still owed by the block
  class window_match_predictor;
    bwtm_pkg::cfg_t                      settings;
    bit                                  line_above_q [FrameMaxW];
    bit                                  line_two_above_q [FrameMaxW];
    bit [8:0]                            window_q;
    int unsigned                         col_in;
    int unsigned                         row_in;
    logic [bwtm_pkg::CountW-1:0]         changes_q;
    bwtm_pkg::out_req_t                  expected_pixels [$];
    int unsigned                         mismatches;

    function new();
      settings = '{image_width: 11'd1024, image_height: 11'd1024,
                   template_codes: 18'h3FFFF, match_required: 4'd9,
                   fg_action: bwtm_pkg::ACT_KEEP, bg_action: bwtm_pkg::ACT_KEEP};
      window_q    = '0;
      col_in      = 0;
      row_in      = 0;
      changes_q   = '0;
      mismatches  = 0;
    endfunction

    function void write_register(bwtm_pkg::reg_e idx, logic [31:0] value);
      case (idx)
        bwtm_pkg::REG_WIDTH:  settings.image_width    = value[10:0];
        bwtm_pkg::REG_HEIGHT: settings.image_height   = value[10:0];
        bwtm_pkg::REG_CODES:  settings.template_codes = value[17:0];
        bwtm_pkg::REG_THRESH: settings.match_required = value[3:0];
        bwtm_pkg::REG_FG:     settings.fg_action      = value[1:0];
        bwtm_pkg::REG_BG:     settings.bg_action      = value[1:0];
        default: ;
      endcase
    endfunction

    // advance the window by one request and queue the pixel it completes
    function void take_request(bwtm_pkg::in_req_t req);
      int unsigned        w, h, c, r, cr, cc, hits, i, j;
      bit                 px, emit, nbr, centre, res, chg;
      bit [2:0]           column;
      logic [1:0]         code, act;
      bwtm_pkg::out_req_t pixel;
      w = (settings.image_width == 0) ? 1 :
          (settings.image_width > FrameMaxW) ? FrameMaxW : settings.image_width;
      h = (settings.image_height == 0) ? 1 :
          (settings.image_height > FrameMaxH) ? FrameMaxH : settings.image_height;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      if (row_in > h + 1) begin
        col_in    = 0;
        row_in    = 0;
        changes_q = '0;
      end
      c  = col_in;
      r  = row_in;
      px = (req.operation == bwtm_pkg::OP_FLUSH) ? 1'b0 : req.pixel_in;
      column = {px, line_above_q[c], line_two_above_q[c]};
      line_two_above_q[c] = line_above_q[c];
      line_above_q[c]     = px;
      window_q = {column, window_q[8:3]};
      emit = 1'b0;
      cr   = 0;
      cc   = 0;
      if (c >= 1) begin
        if (r >= 1) begin
          cr   = r - 1;
          cc   = c - 1;
          emit = 1'b1;
        end
      end else if (r >= 2) begin
        cr   = r - 2;
        cc   = w - 1;
        emit = 1'b1;
      end
      if (c + 1 >= w) begin
        col_in = 0;
        row_in++;
      end else begin
        col_in++;
      end
      if (!emit || cr >= h) return;
      hits = 0;
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          nbr = !((i == 0 && cr < 1) || (i == 2 && cr + 1 >= h) ||
                  (j == 0 && cc < 1) || (j == 2 && cc + 1 >= w)) && window_q[3*j+i];
          code = settings.template_codes[2*(3*i+j) +: 2];
          if (code == bwtm_pkg::CELL_ANY || (code == bwtm_pkg::CELL_ZERO && !nbr) ||
              (code == bwtm_pkg::CELL_ONE && nbr))
            hits++;
        end
      end
      centre = window_q[4];
      act = (hits >= settings.match_required) ? settings.fg_action : settings.bg_action;
      case (act)
        bwtm_pkg::ACT_ZERO: res = 1'b0;
        bwtm_pkg::ACT_ONE:  res = 1'b1;
        default:            res = centre;
      endcase
      chg = (res != centre);
      if (chg && changes_q != bwtm_pkg::COUNT_MAX) changes_q++;
      pixel.pixel_out    = res;
      pixel.changed      = chg;
      pixel.last         = (cr == h - 1 && cc == w - 1);
      pixel.change_count = changes_q;
      expected_pixels.push_back(pixel);
      if (pixel.last) begin
        col_in    = 0;
        row_in    = 0;
        changes_q = '0;
      end
    endfunction

    function void compare_result(bwtm_pkg::out_req_t got);
      bwtm_pkg::out_req_t want;
      if (expected_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: pixel %0b changed %0b last %0b count %0d",
                   got.pixel_out, got.changed, got.last, got.change_count);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out || got.changed !== want.changed ||
          got.last !== want.last || got.change_count !== want.change_count) begin
        if (mismatches < 10)
          $display({"mismatch: expected pixel %0b changed %0b last %0b count %0d,",
                    " got %0b %0b %0b %0d"},
                   want.pixel_out, want.changed, want.last, want.change_count,
                   got.pixel_out, got.changed, got.last, got.change_count);
        mismatches++;
      end
    endfunction
  endclass

  // dut ports, all at known values from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  bwtm_pkg::in_req_t  in_req_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  bwtm_pkg::out_req_t out_req_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [4:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  window_match_predictor board;

  // quiet turns off random idling on both sides
  bit          quiet        = 1'b0;
  // raised by the stimulus, picked up and cleared by the receiver
  bit          hold_pending = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;

  binary_window_template_match_unit #(
    .MAX_WIDTH (FrameMaxW),
    .MAX_HEIGHT(FrameMaxH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // handshake monitor: values read right after the edge are the pre-edge ones,
  // since every driver updates through nonblocking assignments
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.take_request(in_req_i);
      if (out_valid_o && !out_stall_i) board.compare_result(out_req_o);
    end
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 26);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // register write: setup cycle, then access until pready; psel stays up so
  // back-to-back writes never lower and raise it in the same step
  task automatic write_register(input bwtm_pkg::reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_register(idx, value);
  endtask

  // one request; random idle cycles ahead of it unless quiet
  task automatic send_request(input bwtm_pkg::op_e op, input logic px);
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{operation: op, pixel_in: px};
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
  endtask

  // program all registers, stream whole frames (body plus width + 1 drain
  // requests), then wait until every pixel is back and the pipe has settled
  task automatic run_phase(input logic [10:0] width_reg, input logic [10:0] height_reg,
                           input logic [17:0] codes, input logic [3:0] thresh,
                           input logic [1:0] fg, input logic [1:0] bg,
                           input int unsigned frames, input int unsigned density,
                           input int unsigned flush_pct, input int unsigned drain_pixel_pct);
    int unsigned w, h, f, k;
    write_register(bwtm_pkg::REG_WIDTH, 32'(width_reg));
    write_register(bwtm_pkg::REG_HEIGHT, 32'(height_reg));
    write_register(bwtm_pkg::REG_CODES, 32'(codes));
    write_register(bwtm_pkg::REG_THRESH, 32'(thresh));
    write_register(bwtm_pkg::REG_FG, 32'(fg));
    write_register(bwtm_pkg::REG_BG, 32'(bg));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // sizes of 0 act as 1, oversize saturates
    w = (width_reg == 0) ? 1 : (width_reg > FrameMaxW) ? FrameMaxW : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > FrameMaxH) ? FrameMaxH : height_reg;
    for (f = 0; f < frames; f++) begin
      // frame body: mostly pixels, flush requests inside act as 0 pixels
      for (k = 0; k < w * h; k++)
        send_request(($urandom_range(99) < flush_pct) ? bwtm_pkg::OP_FLUSH
                                                      : bwtm_pkg::OP_PIXEL,
                     $urandom_range(99) < density);
      // drain: mostly flush, pixel requests here land outside the frame
      for (k = 0; k < w + 1; k++)
        send_request(($urandom_range(99) < drain_pixel_pct) ? bwtm_pkg::OP_PIXEL
                                                            : bwtm_pkg::OP_FLUSH,
                     $urandom_range(1));
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned phase, random_base, wsel;
    logic [10:0] w_reg, h_reg;
    logic [3:0]  thresh;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero sizes act as a single pixel; all cells don't care with threshold 0
    run_phase(11'd0, 11'd0, 18'h3FFFF, 4'd0, bwtm_pkg::ACT_ONE, bwtm_pkg::ACT_ZERO,
              1, 0, 0, 0);
    // threshold above 9 never met; background action code 3 keeps the input;
    // drain made of pixel requests
    run_phase(11'd3, 11'd2, 18'h1B6D9, 4'd10, bwtm_pkg::ACT_ZERO, 2'd3, 1, 100, 0, 100);
    // all cells match 0 with full threshold, flush requests inside the frame
    run_phase(11'd2, 11'd3, 18'h00000, 4'd9, bwtm_pkg::ACT_ONE, bwtm_pkg::ACT_ZERO,
              1, 40, 50, 0);

    // receiver holds off for a long stretch while requests keep coming,
    // so the block backs up and stalls its input
    quiet        = 1'b1;
    hold_pending = 1'b1;
    run_phase(11'd16, 11'd4, 18'($urandom), 4'($urandom_range(0, 9)),
              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1, 50, 5, 10);
    quiet = 1'b0;

    // random phases, mostly small frames; a run of phases with no idling
    phase       = 0;
    random_base = requests_sent;
    while (requests_sent < random_base + RandomItems) begin
      quiet = (phase >= 2 && phase < 4);
      wsel  = $urandom_range(99);
      w_reg = (wsel < 5) ? 11'd0 :
              (wsel < 85) ? 11'($urandom_range(1, 10)) : 11'($urandom_range(11, 40));
      h_reg = 11'($urandom_range(0, 6));
      thresh = ($urandom_range(99) < 80) ? 4'($urandom_range(0, 9)) :
                                           4'($urandom_range(10, 15));
      run_phase(w_reg, h_reg, 18'($urandom), thresh,
                2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                $urandom_range(1, 3), $urandom_range(0, 100),
                $urandom_range(0, 15), $urandom_range(0, 30));
      phase++;
    end

    // tallest frame (register all ones saturates to the maximum), no idling
    quiet = 1'b1;
    run_phase(11'd1, 11'd2047, 18'h3FFFF, 4'd15, bwtm_pkg::ACT_ONE, bwtm_pkg::ACT_ZERO,
              1, 50, 5, 10);
    quiet = 1'b0;

    repeat (SettleCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_pixels.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* binary_window_template_match_unit.f */
rtl/bwtm_pkg.sv
rtl/bwtm_cfg_regs.sv
rtl/bwtm_line_mem.sv
rtl/bwtm_scan_ctrl.sv
rtl/bwtm_match_core.sv
rtl/binary_window_template_match_unit.sv
bench/binary_window_template_match_unit_test.sv
